// ===== rtl/float_pixel_to_packed_rgb_core_defines.svh =====
// Assertion macros shared by the pixel packer RTL.
// Both macros expect clk and rst_n in the enclosing scope.
`ifndef FLOAT_PIXEL_TO_PACKED_RGB_CORE_DEFINES_SVH
`define FLOAT_PIXEL_TO_PACKED_RGB_CORE_DEFINES_SVH

// Same-cycle implication.
`define FPX2RGB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FPX2RGB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fpx2rgb_pkg.sv =====
// Types and constants for the fixed-point pixel packer.
// No dependencies; used by the interfaces, the pack stage and the top level.
package fpx2rgb_pkg;

    localparam int IN_W      = 18;   // signed Q2.16 channel
    localparam int CH_W      = 17;   // clipped channel, 0..1.0
    localparam int MUL_W     = 24;   // per-channel multiplier
    localparam int PROD_W    = 40;   // product of clipped channel and multiplier
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 3;

    localparam logic [CH_W-1:0] CH_ONE = CH_W'(17'h10000);

    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FORMAT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HAS_ALPHA = 2'd1;

    typedef enum logic [2:0] {
        FMT_RGB8,
        FMT_BGR565,
        FMT_RGB565,
        FMT_BGR888,
        FMT_RGB888,
        FMT_RGBA8888,
        FMT_ARGB8888,
        FMT_BGR8888
    } fmt_t;

    typedef struct packed {
        fmt_t fmt;
        logic alpha;
    } ctl_t;

    typedef struct packed {
        logic [PROD_W-1:0] r;
        logic [PROD_W-1:0] g;
        logic [PROD_W-1:0] b;
        logic [7:0]        a8;
    } prod_t;

endpackage

// ===== rtl/fpx2rgb_if.sv =====
// Valid/ready channel interfaces for the pixel packer: pixel in, word out, config writes.
// Depends on fpx2rgb_pkg.
interface fpx2rgb_pix_if
    import fpx2rgb_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] red_in;
    logic signed [IN_W-1:0] green_in;
    logic signed [IN_W-1:0] blue_in;
    logic signed [IN_W-1:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface fpx2rgb_out_if
    import fpx2rgb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  pixel_word;
    logic [COUNT_W-1:0] byte_count;

    modport source (output valid, pixel_word, byte_count, input ready);
    modport sink   (input valid, pixel_word, byte_count, output ready);
endinterface

interface fpx2rgb_cfg_if
    import fpx2rgb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fpx2rgb_pack.sv =====
// Final packing: picks the bit fields of the three channel products and lays
// them out in the selected memory format. Depends on fpx2rgb_pkg.
module fpx2rgb_pack
    import fpx2rgb_pkg::*;
(
    input  ctl_t               ctl,
    input  prod_t              prod,
    output logic [WORD_W-1:0]  word,
    output logic [COUNT_W-1:0] count
);

    localparam logic [COUNT_W-1:0] CNT_1 = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] CNT_2 = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] CNT_3 = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] CNT_4 = COUNT_W'(4);

    logic [23:0] vr, vg, vb;
    logic [7:0]  lr, lg, lb;
    logic [7:0]  rgb8;
    logic [7:0]  alpha_byte;

    // Drop the 16 fraction bits of each product.
    assign vr = prod.r[PROD_W-1:16];
    assign vg = prod.g[PROD_W-1:16];
    assign vb = prod.b[PROD_W-1:16];
    assign lr = vr[7:0];
    assign lg = vg[7:0];
    assign lb = vb[7:0];

    assign rgb8       = 8'(lr << 6) + 8'(lg << 2) + lb;
    assign alpha_byte = ctl.alpha ? prod.a8 : 8'hff;

    always_comb
    begin
        word  = '0;
        count = CNT_1;
        case (ctl.fmt)
            FMT_RGB8:
            begin
                // premultiplied form takes the top bits of the 24-bit products
                word  = ctl.alpha ? {24'd0, vr[23:22], vg[23:21], vb[23:21]}
                                  : {24'd0, rgb8};
                count = CNT_1;
            end
            FMT_BGR565:
            begin
                word  = ctl.alpha ? {16'd0, vb[23:19], vg[23:18], vr[23:19]}
                                  : {16'd0, lb[4:0], lg[5:0], lr[4:0]};
                count = CNT_2;
            end
            FMT_RGB565:
            begin
                word  = ctl.alpha ? {16'd0, vr[23:19], vg[23:18], vb[23:19]}
                                  : {16'd0, lr[4:0], lg[5:0], lb[4:0]};
                count = CNT_2;
            end
            FMT_BGR888:
            begin
                word  = {8'd0, lr, lg, lb};
                count = CNT_3;
            end
            FMT_RGB888:
            begin
                word  = {8'd0, lb, lg, lr};
                count = CNT_3;
            end
            FMT_RGBA8888:
            begin
                word  = {alpha_byte, lb, lg, lr};
                count = CNT_4;
            end
            FMT_ARGB8888:
            begin
                word  = {lb, lg, lr, alpha_byte};
                count = CNT_4;
            end
            FMT_BGR8888:
            begin
                word  = {8'd0, lr, lg, lb};
                count = CNT_4;
            end
            default:
            begin
                word  = '0;
                count = CNT_1;
            end
        endcase
    end

endmodule

// ===== rtl/float_pixel_to_packed_rgb_core.sv =====
// Pixel packer top level: four register stages (clip, multiplier select,
// multiply, pack) behind a valid/ready handshake on each side.
// An accepted request passes each stage register in order. Throughput: one
// pixel per cycle unless the output stalls; each stage advances when it is
// empty or the stage after it moves; bubbles close up, stalls lose nothing.
// Reset clears all stage valid bits and sets format RGB8, opaque source.
`include "float_pixel_to_packed_rgb_core_defines.svh"

module float_pixel_to_packed_rgb_core
    import fpx2rgb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    fpx2rgb_pix_if.sink   pixel,
    fpx2rgb_out_if.source result,
    fpx2rgb_cfg_if.sink   cfg
);

    localparam logic [MUL_W-1:0] K3   = MUL_W'(3);
    localparam logic [MUL_W-1:0] K7   = MUL_W'(7);
    localparam logic [MUL_W-1:0] K31  = MUL_W'(31);
    localparam logic [MUL_W-1:0] K63  = MUL_W'(63);
    localparam logic [MUL_W-1:0] K255 = MUL_W'(255);

    function automatic logic [CH_W-1:0] clip_ch(input logic signed [IN_W-1:0] raw);
        logic [CH_W-1:0] mag;
        mag = raw[IN_W-2:0];
        if (raw[IN_W-1])
            return '0;
        else if (mag > CH_ONE)
            return CH_ONE;
        else
            return mag;
    endfunction

    // configuration
    fmt_t fmt_reg,   fmt_next;
    logic alpha_reg, alpha_next;

    // stage valids and ready chain
    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next, v4_reg, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: clipped channels
    logic [CH_W-1:0] s1_r_reg, s1_g_reg, s1_b_reg, s1_a_reg;
    ctl_t            s1_ctl_reg;

    // stage 2: channels with their multipliers
    logic [CH_W-1:0]  s2_r_reg, s2_g_reg, s2_b_reg;
    logic [MUL_W-1:0] s2_mr_reg, s2_mg_reg, s2_mb_reg;
    logic [MUL_W-1:0] mr_next, mg_next, mb_next;
    logic [7:0]       s2_a8_reg;
    ctl_t             s2_ctl_reg;
    logic [CH_W+7:0]  ca255;
    logic [7:0]       a8;

    // stage 3: products
    prod_t                 s3_prod_reg;
    ctl_t                  s3_ctl_reg;
    logic [CH_W+MUL_W-1:0] pr_full, pg_full, pb_full;

    // stage 4: output register
    logic [WORD_W-1:0]  s4_word_reg;
    logic [COUNT_W-1:0] s4_count_reg;
    logic [WORD_W-1:0]  word_next;
    logic [COUNT_W-1:0] count_next;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_comb
    begin
        fmt_next   = fmt_reg;
        alpha_next = alpha_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_OUTPUT_FORMAT:    fmt_next   = fmt_t'(cfg.data);
                CFG_SOURCE_HAS_ALPHA: alpha_next = cfg.data[0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_RGB8;
            alpha_reg <= 1'b0;
        end
        else
        begin
            fmt_reg   <= fmt_next;
            alpha_reg <= alpha_next;
        end
    end

    // ---------------- pipeline control ----------------
    assign rdy4 = !v4_reg || result.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign pixel.ready = rdy1;

    assign v1_next = rdy1 ? pixel.valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg      : v2_reg;
    assign v3_next = rdy3 ? v2_reg      : v3_reg;
    assign v4_next = rdy4 ? v3_reg      : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // ---------------- stage 1: clip ----------------
    always_ff @(posedge clk)
    begin
        if (rdy1 && pixel.valid)
        begin
            s1_r_reg   <= clip_ch(pixel.red_in);
            s1_g_reg   <= clip_ch(pixel.green_in);
            s1_b_reg   <= clip_ch(pixel.blue_in);
            s1_a_reg   <= clip_ch(pixel.alpha_in);
            s1_ctl_reg <= '{fmt: fmt_reg, alpha: alpha_reg};
        end
    end

    // ---------------- stage 2: multiplier select ----------------
    // alpha * 255 by shift and subtract; its top byte is the 8-bit alpha
    assign ca255 = {s1_a_reg, 8'd0} - {8'd0, s1_a_reg};
    assign a8    = ca255[23:16];

    always_comb
    begin
        mr_next = K255;
        mg_next = K255;
        mb_next = K255;
        case (s1_ctl_reg.fmt)
            FMT_RGB8:
            begin
                if (s1_ctl_reg.alpha)
                begin
                    mr_next = ca255[MUL_W-1:0];
                    mg_next = ca255[MUL_W-1:0];
                    mb_next = ca255[MUL_W-1:0];
                end
                else
                begin
                    mr_next = K3;
                    mg_next = K7;
                    mb_next = K3;
                end
            end
            FMT_BGR565, FMT_RGB565:
            begin
                if (s1_ctl_reg.alpha)
                begin
                    mr_next = ca255[MUL_W-1:0];
                    mg_next = ca255[MUL_W-1:0];
                    mb_next = ca255[MUL_W-1:0];
                end
                else
                begin
                    mr_next = K31;
                    mg_next = K63;
                    mb_next = K31;
                end
            end
            FMT_BGR888, FMT_RGB888, FMT_BGR8888:
            begin
                // premultiply by the 8-bit alpha
                if (s1_ctl_reg.alpha)
                begin
                    mr_next = MUL_W'(a8);
                    mg_next = MUL_W'(a8);
                    mb_next = MUL_W'(a8);
                end
            end
            FMT_RGBA8888, FMT_ARGB8888:
            begin
                mr_next = K255;
                mg_next = K255;
                mb_next = K255;
            end
            default:
            begin
                mr_next = K255;
                mg_next = K255;
                mb_next = K255;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            s2_r_reg   <= s1_r_reg;
            s2_g_reg   <= s1_g_reg;
            s2_b_reg   <= s1_b_reg;
            s2_mr_reg  <= mr_next;
            s2_mg_reg  <= mg_next;
            s2_mb_reg  <= mb_next;
            s2_a8_reg  <= a8;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // ---------------- stage 3: multiply ----------------
    assign pr_full = (CH_W+MUL_W)'(s2_r_reg) * (CH_W+MUL_W)'(s2_mr_reg);
    assign pg_full = (CH_W+MUL_W)'(s2_g_reg) * (CH_W+MUL_W)'(s2_mg_reg);
    assign pb_full = (CH_W+MUL_W)'(s2_b_reg) * (CH_W+MUL_W)'(s2_mb_reg);

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            s3_prod_reg.r  <= pr_full[PROD_W-1:0];
            s3_prod_reg.g  <= pg_full[PROD_W-1:0];
            s3_prod_reg.b  <= pb_full[PROD_W-1:0];
            s3_prod_reg.a8 <= s2_a8_reg;
            s3_ctl_reg     <= s2_ctl_reg;
        end
    end

    // ---------------- stage 4: pack ----------------
    fpx2rgb_pack u_pack (
        .ctl   (s3_ctl_reg),
        .prod  (s3_prod_reg),
        .word  (word_next),
        .count (count_next)
    );

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            s4_word_reg  <= word_next;
            s4_count_reg <= count_next;
        end
    end

    assign result.valid      = v4_reg;
    assign result.pixel_word = s4_word_reg;
    assign result.byte_count = s4_count_reg;

    // ---------------- assertions ----------------
    `FPX2RGB_ASSERT_IMP(a_one_byte_clean, result.valid && result.byte_count == 3'd1,
        result.pixel_word[31:8] == 24'd0, "one-byte pixel has upper bytes set")
    `FPX2RGB_ASSERT_IMP(a_two_byte_clean, result.valid && result.byte_count == 3'd2,
        result.pixel_word[31:16] == 16'd0, "two-byte pixel has upper bytes set")
    `FPX2RGB_ASSERT_NXT(a_stall_keeps_item, v3_reg && !rdy3, v3_reg,
        "stalled product stage lost its item")
    `FPX2RGB_ASSERT_NXT(a_request_enters, pixel.valid && pixel.ready, v1_reg,
        "accepted request missing from clip stage")

endmodule
